@@ rtl/core/spiral_matrix_scan_unit_defines.svh @@
// Assertion macros shared by the spiral matrix scan RTL.
`ifndef SPIRAL_MATRIX_SCAN_UNIT_DEFINES_SVH
`define SPIRAL_MATRIX_SCAN_UNIT_DEFINES_SVH

`ifndef SYNTHESIS
// Property holds on every clock edge outside reset.
`define SMS_ASSERT(label, prop) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) \
    else $error("spiral scan check failed");
// Consequent must hold in the cycle after the antecedent.
`define SMS_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("spiral scan sequencing check failed");
`else
`define SMS_ASSERT(label, prop)
`define SMS_ASSERT_NEXT(label, ante, cons)
`endif

`endif

@@ rtl/core/sms_pkg.sv @@
// Shared constants, types and helpers of the spiral matrix scan unit.
package sms_pkg;

  localparam int MAX_DIM = 32;
  localparam int ELEM_W  = 32;
  localparam int DIM_W   = $clog2(MAX_DIM + 1);
  localparam int POS_W   = $clog2(MAX_DIM);
  localparam int DEPTH   = MAX_DIM * MAX_DIM;
  localparam int ADDR_W  = $clog2(DEPTH);
  localparam int CNT_W   = ADDR_W + 1;
  localparam int CFG_IDX_W = 2;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_NUM_COLS = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_NUM_ROWS = 2'd1;

  // input operations
  localparam logic OP_LOAD  = 1'b0;
  localparam logic OP_FETCH = 1'b1;

  // walk direction
  localparam logic [1:0] DIR_RIGHT = 2'd0;
  localparam logic [1:0] DIR_DOWN  = 2'd1;
  localparam logic [1:0] DIR_LEFT  = 2'd2;
  localparam logic [1:0] DIR_UP    = 2'd3;

  typedef logic [POS_W-1:0]  pos_t;
  typedef logic [DIM_W-1:0]  dim_t;
  typedef logic [ADDR_W-1:0] addr_t;
  typedef logic [CNT_W-1:0]  cnt_t;
  typedef logic [ELEM_W-1:0] elem_t;

  // zero reads as one, anything above MAX_DIM saturates
  function automatic dim_t clamp_dim(input dim_t v);
    dim_t d;
    d = v;
    if (d == '0) begin
      d = dim_t'(1);
    end else if (d > dim_t'(MAX_DIM)) begin
      d = dim_t'(MAX_DIM);
    end
    return d;
  endfunction

endpackage

@@ rtl/core/spiral_matrix_scan_unit.sv @@
// Top level of the spiral matrix scan unit: matrix store and spiral reader.
// Input channel (in_valid / in_stall, payload op and elem_value): a load beat
// (op = 0) writes the next element in row-major order and gives no result;
// a fetch beat (op = 1) returns the next element of the clockwise spiral.
// Output channel (out_valid / out_stall): out_value, out_row, out_col and
// is_last, one beat per fetch, in fetch order.
// Config port: cfg_wr_en writes cfg_data to register cfg_index (0 = columns,
// 1 = rows); a write also restarts the writer and the reader. Write only idle.
// Fetch path: the memory read register takes the element, then the output
// register takes it once it is free or being emptied.
// Throughput: one beat per cycle for loads and fetches while in_stall is low;
// the single port of the 1024 x 32 matrix memory takes one access per cycle.
// Receiver stall: the result waits in the output register and the next
// read waits in the memory read register; once both are occupied in_stall
// rises until out_stall drops.
// Reset: dimensions return to 1 x 1, the writer and reader to position zero.
// Memory contents are undefined until loaded; no clearing pass runs.
`include "spiral_matrix_scan_unit_defines.svh"

module spiral_matrix_scan_unit import sms_pkg::*; (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    cfg_wr_en,
  input  logic [CFG_IDX_W-1:0]    cfg_index,
  input  logic [DIM_W-1:0]        cfg_data,
  input  logic                    in_valid,
  output logic                    in_stall,
  input  logic                    op,
  input  logic signed [ELEM_W-1:0] elem_value,
  output logic                    out_valid,
  input  logic                    out_stall,
  output logic signed [ELEM_W-1:0] out_value,
  output logic [POS_W-1:0]        out_row,
  output logic [POS_W-1:0]        out_col,
  output logic                    is_last
);

  elem_t mem [0:DEPTH-1];
  elem_t rdata;

  dim_t  num_cols, num_cols_next;
  dim_t  num_rows, num_rows_next;
  addr_t write_index, write_index_next;
  pos_t  cur_row, cur_row_next;
  pos_t  cur_col, cur_col_next;
  pos_t  ring_index, ring_index_next;
  logic [1:0] direction, direction_next;
  cnt_t  emitted_count, emitted_count_next;

  logic  rd_pend, rd_pend_next;
  pos_t  pend_row, pend_col;
  logic  pend_last;

  logic  in_acc, load_acc, fetch_acc, out_load;
  cnt_t  total, wi_inc, rd_lin;
  addr_t rd_addr;
  logic  last_hit;
  dim_t  ring_w, end_x, end_y, col_w, row_w;
  pos_t  ring_inc;

  assign total    = cnt_t'({5'b0, num_rows} * {5'b0, num_cols});
  assign rd_lin   = cnt_t'({6'b0, cur_row} * {5'b0, num_cols}) + cnt_t'(cur_col);
  assign rd_addr  = rd_lin[ADDR_W-1:0];
  assign last_hit = (emitted_count + cnt_t'(1)) >= total;
  assign wi_inc   = cnt_t'(write_index) + cnt_t'(1);

  // output register is free, or being emptied this edge
  assign out_load  = rd_pend && (!out_valid || !out_stall);
  assign in_stall  = rd_pend && !out_load;
  assign in_acc    = in_valid && !in_stall;
  assign load_acc  = in_acc && (op == OP_LOAD);
  assign fetch_acc = in_acc && (op == OP_FETCH);
  assign rd_pend_next = fetch_acc || (rd_pend && !out_load);

  assign ring_w   = dim_t'(ring_index);
  assign col_w    = dim_t'(cur_col);
  assign row_w    = dim_t'(cur_row);
  assign end_x    = num_cols - dim_t'(1) - ring_w;
  assign end_y    = num_rows - dim_t'(1) - ring_w;
  assign ring_inc = ring_index + pos_t'(1);

  always_comb begin
    num_cols_next      = num_cols;
    num_rows_next      = num_rows;
    write_index_next   = write_index;
    cur_row_next       = cur_row;
    cur_col_next       = cur_col;
    ring_index_next    = ring_index;
    direction_next     = direction;
    emitted_count_next = emitted_count;

    if (cfg_wr_en && (cfg_index inside {CFG_NUM_COLS, CFG_NUM_ROWS})) begin
      if (cfg_index == CFG_NUM_COLS) begin
        num_cols_next = clamp_dim(cfg_data);
      end else begin
        num_rows_next = clamp_dim(cfg_data);
      end
      write_index_next   = '0;
      cur_row_next       = '0;
      cur_col_next       = '0;
      ring_index_next    = '0;
      direction_next     = DIR_RIGHT;
      emitted_count_next = '0;
    end else if (load_acc) begin
      if (write_index == '0) begin
        cur_row_next       = '0;
        cur_col_next       = '0;
        ring_index_next    = '0;
        direction_next     = DIR_RIGHT;
        emitted_count_next = '0;
      end
      write_index_next = (wi_inc >= total) ? '0 : wi_inc[ADDR_W-1:0];
    end else if (fetch_acc) begin
      if (last_hit) begin
        cur_row_next       = '0;
        cur_col_next       = '0;
        ring_index_next    = '0;
        direction_next     = DIR_RIGHT;
        emitted_count_next = '0;
      end else begin
        emitted_count_next = emitted_count + cnt_t'(1);
        // a ring ends when no turn is left; step to the next inner corner
        case (direction)
          DIR_RIGHT: begin
            if (col_w < end_x) begin
              cur_col_next = cur_col + pos_t'(1);
            end else if (ring_w < end_y) begin
              direction_next = DIR_DOWN;
              cur_row_next   = cur_row + pos_t'(1);
            end else begin
              ring_index_next = ring_inc;
              direction_next  = DIR_RIGHT;
              cur_row_next    = ring_inc;
              cur_col_next    = ring_inc;
            end
          end
          DIR_DOWN: begin
            if (row_w < end_y) begin
              cur_row_next = cur_row + pos_t'(1);
            end else if (ring_w < end_x) begin
              direction_next = DIR_LEFT;
              cur_col_next   = cur_col - pos_t'(1);
            end else begin
              ring_index_next = ring_inc;
              direction_next  = DIR_RIGHT;
              cur_row_next    = ring_inc;
              cur_col_next    = ring_inc;
            end
          end
          DIR_LEFT: begin
            if (col_w > ring_w) begin
              cur_col_next = cur_col - pos_t'(1);
            end else if (ring_w + dim_t'(1) < end_y) begin
              direction_next = DIR_UP;
              cur_row_next   = cur_row - pos_t'(1);
            end else begin
              ring_index_next = ring_inc;
              direction_next  = DIR_RIGHT;
              cur_row_next    = ring_inc;
              cur_col_next    = ring_inc;
            end
          end
          default: begin
            if (row_w > ring_w + dim_t'(1)) begin
              cur_row_next = cur_row - pos_t'(1);
            end else begin
              ring_index_next = ring_inc;
              direction_next  = DIR_RIGHT;
              cur_row_next    = ring_inc;
              cur_col_next    = ring_inc;
            end
          end
        endcase
      end
    end
  end

  // matrix memory: one write or one read per cycle, read data registered
  always_ff @(posedge clk) begin
    if (load_acc) begin
      mem[write_index] <= elem_t'(elem_value);
    end
    if (fetch_acc) begin
      rdata <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      num_cols      <= dim_t'(1);
      num_rows      <= dim_t'(1);
      write_index   <= '0;
      cur_row       <= '0;
      cur_col       <= '0;
      ring_index    <= '0;
      direction     <= DIR_RIGHT;
      emitted_count <= '0;
      rd_pend       <= 1'b0;
      out_valid     <= 1'b0;
    end else begin
      num_cols      <= num_cols_next;
      num_rows      <= num_rows_next;
      write_index   <= write_index_next;
      cur_row       <= cur_row_next;
      cur_col       <= cur_col_next;
      ring_index    <= ring_index_next;
      direction     <= direction_next;
      emitted_count <= emitted_count_next;
      rd_pend       <= rd_pend_next;
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  // position of the read in flight, and the output register
  always_ff @(posedge clk) begin
    if (fetch_acc) begin
      pend_row  <= cur_row;
      pend_col  <= cur_col;
      pend_last <= last_hit;
    end
    if (out_load) begin
      out_value <= $signed(rdata);
      out_row   <= pend_row;
      out_col   <= pend_col;
      is_last   <= pend_last;
    end
  end

  `SMS_ASSERT(a_wr_index_in_range, cnt_t'(write_index) < total)
  `SMS_ASSERT(a_emitted_in_range, emitted_count < total)
  `SMS_ASSERT_NEXT(a_fetch_sets_pending, fetch_acc, rd_pend)
  `SMS_ASSERT_NEXT(a_drain_fills_output, out_load, out_valid)
  `SMS_ASSERT_NEXT(a_blocked_read_holds, rd_pend && !out_load,
                   rd_pend && $stable(pend_row) && $stable(pend_col) && $stable(rdata))

endmodule
